[rtl/xps_pkg.sv]
// Shared types, character codes and the CRC-16 step for the XMODEM packet sender.
// No dependencies; xps_ctrl and the top level refer to it by scoped names, the testbench files import it.
`timescale 1ns / 1ps
package xps_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int INDEX_W     = 8;
  localparam int HDR_BYTES   = 3;

  localparam logic [INDEX_W-1:0] FILL_END   = INDEX_W'(BLOCK_BYTES);
  localparam logic [INDEX_W-1:0] HDR_LEN    = INDEX_W'(HDR_BYTES);
  localparam logic [INDEX_W-1:0] CHECK_HI   = INDEX_W'(HDR_BYTES + BLOCK_BYTES);
  localparam logic [INDEX_W-1:0] LAST_SUM   = INDEX_W'(HDR_BYTES + BLOCK_BYTES);
  localparam logic [INDEX_W-1:0] LAST_CRC   = INDEX_W'(HDR_BYTES + BLOCK_BYTES + 1);
  localparam logic [INDEX_W-1:0] IDX_NUM    = INDEX_W'(1);
  localparam logic [INDEX_W-1:0] IDX_NUM_N  = INDEX_W'(2);

  localparam logic [15:0] BLOCK_COUNT_RST = 16'd256;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [1:0] REQ_HOST = 2'd0;
  localparam logic [1:0] REQ_DATA = 2'd1;
  localparam logic [1:0] REQ_TX   = 2'd2;

  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FILL,
    PH_SEND,
    PH_WAIT_ACK,
    PH_EOT,
    PH_EOT_ACK
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       from_ram;
    logic       last;
  } xps_res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } xps_ram_req_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

[rtl/xps_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module xps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/xps_ctrl.sv]
// Protocol sequencer: phase, packet counters, running check value, RAM requests.
// Depends on xps_pkg.
`timescale 1ns / 1ps
module xps_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [1:0]            req_type,
  input  logic [7:0]            in_byte,
  input  logic [15:0]           block_count,
  output xps_pkg::xps_res_t     res,
  output xps_pkg::xps_ram_req_t ram_req
);

  xps_pkg::phase_t phase, phase_next;
  logic                        crc_sel, crc_sel_next;
  logic [7:0]                  packet_number, packet_number_next;
  logic [15:0]                 blocks_sent, blocks_sent_next;
  logic [xps_pkg::INDEX_W-1:0] fill_index, fill_index_next;
  logic [xps_pkg::INDEX_W-1:0] send_index, send_index_next;
  logic [15:0]                 check_value, check_value_next;

  logic                        do_rearm;
  logic                        do_start;
  logic [xps_pkg::INDEX_W-1:0] data_off;
  logic [xps_pkg::INDEX_W-1:0] fill_inc;
  logic                        is_last;

  assign data_off = send_index - xps_pkg::HDR_LEN;
  assign fill_inc = fill_index + xps_pkg::INDEX_W'(1);
  assign is_last  = crc_sel ? (send_index >= xps_pkg::LAST_CRC)
                            : (send_index >= xps_pkg::LAST_SUM);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= xps_pkg::PH_IDLE;
      crc_sel       <= 1'b0;
      packet_number <= 8'd1;
      blocks_sent   <= '0;
      fill_index    <= '0;
      send_index    <= '0;
      check_value   <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      crc_sel       <= crc_sel_next;
      packet_number <= packet_number_next;
      blocks_sent   <= blocks_sent_next;
      fill_index    <= fill_index_next;
      send_index    <= send_index_next;
      check_value   <= check_value_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    crc_sel_next       = crc_sel;
    packet_number_next = packet_number;
    blocks_sent_next   = blocks_sent;
    fill_index_next    = fill_index;
    send_index_next    = send_index;
    check_value_next   = check_value;
    do_rearm           = 1'b0;
    do_start           = 1'b0;
    res                = '0;
    ram_req            = '0;
    ram_req.waddr      = fill_index[xps_pkg::ADDR_W-1:0];
    ram_req.wdata      = in_byte;
    ram_req.raddr      = data_off[xps_pkg::ADDR_W-1:0];

    unique case (req_type)
      xps_pkg::REQ_HOST: begin
        if (phase == xps_pkg::PH_IDLE) begin
          if (in_byte == xps_pkg::CH_ETX) begin
            do_rearm  = 1'b1;
            res.valid = 1'b1;
            res.kind  = xps_pkg::KIND_CANCEL;
          end else if (in_byte == xps_pkg::CH_C || in_byte == xps_pkg::CH_NAK) begin
            crc_sel_next = (in_byte == xps_pkg::CH_C);
            do_start     = 1'b1;
          end
        end else if (phase == xps_pkg::PH_WAIT_ACK) begin
          if (in_byte == xps_pkg::CH_ACK) begin
            blocks_sent_next   = blocks_sent + 16'd1;
            packet_number_next = packet_number + 8'd1;
            do_start           = 1'b1;
          end else if (in_byte == xps_pkg::CH_NAK) begin
            send_index_next = '0;
            phase_next      = xps_pkg::PH_SEND;
          end else if (in_byte == xps_pkg::CH_CAN) begin
            do_rearm  = 1'b1;
            res.valid = 1'b1;
            res.kind  = xps_pkg::KIND_CANCEL;
          end
        end else if (phase == xps_pkg::PH_EOT_ACK) begin
          if (in_byte == xps_pkg::CH_ACK) begin
            do_rearm  = 1'b1;
            res.valid = 1'b1;
            res.kind  = xps_pkg::KIND_DONE;
          end
        end
      end
      xps_pkg::REQ_DATA: begin
        if (phase == xps_pkg::PH_FILL && fill_index < xps_pkg::FILL_END) begin
          ram_req.we       = fire;
          check_value_next = crc_sel ? xps_pkg::crc_step(check_value, in_byte)
                                     : {8'h00, check_value[7:0] + in_byte};
          fill_index_next  = fill_inc;
          if (fill_inc >= xps_pkg::FILL_END) begin
            send_index_next = '0;
            phase_next      = xps_pkg::PH_SEND;
          end
        end
      end
      xps_pkg::REQ_TX: begin
        if (phase == xps_pkg::PH_SEND) begin
          res.valid = 1'b1;
          res.kind  = xps_pkg::KIND_BYTE;
          res.last  = is_last;
          if (send_index == '0) begin
            res.tx_byte = xps_pkg::CH_SOH;
          end else if (send_index == xps_pkg::IDX_NUM) begin
            res.tx_byte = packet_number;
          end else if (send_index == xps_pkg::IDX_NUM_N) begin
            res.tx_byte = ~packet_number;
          end else if (send_index < xps_pkg::CHECK_HI) begin
            res.from_ram = 1'b1;
            ram_req.re   = fire;
          end else if (send_index == xps_pkg::CHECK_HI) begin
            res.tx_byte = crc_sel ? check_value[15:8] : check_value[7:0];
          end else begin
            res.tx_byte = check_value[7:0];
          end
          if (is_last) begin
            send_index_next = '0;
            phase_next      = xps_pkg::PH_WAIT_ACK;
          end else begin
            send_index_next = send_index + xps_pkg::INDEX_W'(1);
          end
        end else if (phase == xps_pkg::PH_EOT) begin
          res.valid   = 1'b1;
          res.kind    = xps_pkg::KIND_BYTE;
          res.tx_byte = xps_pkg::CH_EOT;
          res.last    = 1'b1;
          phase_next  = xps_pkg::PH_EOT_ACK;
        end
      end
      default: begin
      end
    endcase

    if (do_start) begin
      fill_index_next  = '0;
      send_index_next  = '0;
      check_value_next = '0;
      phase_next       = (blocks_sent_next >= block_count) ? xps_pkg::PH_EOT
                                                           : xps_pkg::PH_FILL;
    end

    if (do_rearm) begin
      phase_next         = xps_pkg::PH_IDLE;
      crc_sel_next       = 1'b0;
      packet_number_next = 8'd1;
      blocks_sent_next   = '0;
      fill_index_next    = '0;
      send_index_next    = '0;
      check_value_next   = '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !(ram_req.we && ram_req.re))
    else $error("packet store written and read in one cycle");

  assert property (@(posedge clk) disable iff (rst)
    (phase == xps_pkg::PH_FILL && !crc_sel) |-> (check_value[15:8] == 8'h00))
    else $error("checksum high byte not zero");

  assert property (@(posedge clk) disable iff (rst)
    (phase == xps_pkg::PH_SEND) |-> (fill_index == xps_pkg::FILL_END))
    else $error("sending a packet that is not fully stored");

endmodule

[rtl/xmodem_packet_sender.sv]
// Top level of the XMODEM packet sender: sequencer, packet store RAM, output register.
// Depends on xps_pkg, xps_ram and xps_ctrl.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------
//   in       | in_valid / in_stall     | req_type, in_byte
//   out      | out_valid / out_stall   | result_kind, tx_byte, end_of_packet
//   cfg      | cfg_wr_en               | cfg_wr_data (block_count)
//
// One item is taken per cycle unless in_stall holds it; its result is registered in the output
// register in the cycle after the item, as the packet store read data lands.
// in_stall rises only for an item that makes a result while the output register
// holds a result that is stalled; other items keep flowing.
// Synchronous reset; the packet store needs no clearing, bytes are stored before
// they are sent.
`timescale 1ns / 1ps
module xmodem_packet_sender (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  tx_byte,
  output logic        end_of_packet,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0]           block_count;
  logic                  fire;
  xps_pkg::xps_res_t     res;
  xps_pkg::xps_ram_req_t ram_req;
  logic [7:0]            ram_rdata;
  logic [1:0]            out_kind;
  logic [7:0]            out_byte;
  logic                  out_from_ram;
  logic                  out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= xps_pkg::BLOCK_COUNT_RST;
    end else if (cfg_wr_en) begin
      block_count <= cfg_wr_data;
    end
  end

  assign in_stall = res.valid && out_valid && out_stall;
  assign fire     = in_valid && !in_stall;

  xps_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .req_type    (req_type),
    .in_byte     (in_byte),
    .block_count (block_count),
    .res         (res),
    .ram_req     (ram_req)
  );

  xps_ram #(
    .WIDTH (8),
    .DEPTH (xps_pkg::BLOCK_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_kind     <= res.kind;
      out_byte     <= res.tx_byte;
      out_from_ram <= res.from_ram;
      out_last     <= res.last;
    end
  end

  assign result_kind   = out_kind;
  assign tx_byte       = out_from_ram ? ram_rdata : out_byte;
  assign end_of_packet = out_last;

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with no blocked transfer");

  assert property (@(posedge clk) disable iff (rst)
    (fire && res.valid) |=> out_valid)
    else $error("result lost after accepted item");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_from_ram) |-> (out_kind == xps_pkg::KIND_BYTE && !out_last))
    else $error("stored byte flagged as non-data result");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind != xps_pkg::KIND_BYTE) |-> !out_last && out_byte == 8'h00)
    else $error("cancel or done result carries byte data");

endmodule

[tb/xmodem_packet_sender_checker.sv]
// Checker for the XMODEM packet sender: watches the item, result and register ports,
// predicts each transmitted byte, cancel and completion, and counts mismatches.
// Depends on xps_pkg for the phase type, the sizes, the CRC polynomial and the character, request and result codes.
`timescale 1ns / 1ps
module xmodem_packet_sender_checker
  import xps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  result_kind,
  input  logic [7:0]  tx_byte,
  input  logic        end_of_packet,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          mismatches,
  output int          due_count,
  output int          results_checked
);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       eop;
  } sent_t;

  sent_t       tx_due_q[$];
  phase_t      ph;
  logic        crc_on;
  logic [7:0]  pkt_no;
  logic [15:0] acked;
  logic [15:0] block_limit;
  logic [7:0]  block_buf [BLOCK_BYTES];
  logic [7:0]  fill_pos;
  logic [7:0]  tx_pos;
  logic [15:0] check;

  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = acc[15] ^ b[k];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  task automatic rearm_state();
    ph = PH_IDLE;
    crc_on = 1'b0;
    pkt_no = 8'd1;
    acked = '0;
    fill_pos = '0;
    tx_pos = '0;
    check = '0;
  endtask

  task automatic open_block();
    fill_pos = '0;
    tx_pos = '0;
    check = '0;
    ph = (acked >= block_limit) ? PH_EOT : PH_FILL;
  endtask

  task automatic advance_sender(input logic [1:0] req, input logic [7:0] b);
    sent_t      res;
    logic       emit;
    logic [7:0] last_pos;
    res = '0;
    emit = 1'b0;
    last_pos = crc_on ? 8'(BLOCK_BYTES + 4) : 8'(BLOCK_BYTES + 3);
    case (req)
      REQ_HOST: begin
        case (ph)
          PH_IDLE: begin
            if (b == CH_ETX) begin
              rearm_state();
              res.kind = KIND_CANCEL;
              emit = 1'b1;
            end else if (b == CH_C || b == CH_NAK) begin
              crc_on = (b == CH_C);
              open_block();
            end
          end
          PH_WAIT_ACK: begin
            if (b == CH_ACK) begin
              acked = acked + 16'd1;
              pkt_no = pkt_no + 8'd1;
              open_block();
            end else if (b == CH_NAK) begin
              tx_pos = '0;
              ph = PH_SEND;
            end else if (b == CH_CAN) begin
              rearm_state();
              res.kind = KIND_CANCEL;
              emit = 1'b1;
            end
          end
          PH_EOT_ACK: begin
            if (b == CH_ACK) begin
              rearm_state();
              res.kind = KIND_DONE;
              emit = 1'b1;
            end
          end
          default: ;
        endcase
      end
      REQ_DATA: begin
        if (ph == PH_FILL) begin
          block_buf[fill_pos[ADDR_W-1:0]] = b;
          check = crc_on ? crc16_next(check, b) : {8'h00, check[7:0] + b};
          fill_pos = fill_pos + 8'd1;
          if (fill_pos == 8'(BLOCK_BYTES)) begin
            tx_pos = '0;
            ph = PH_SEND;
          end
        end
      end
      REQ_TX: begin
        if (ph == PH_SEND) begin
          res.kind = KIND_BYTE;
          res.eop = (tx_pos >= last_pos);
          emit = 1'b1;
          if (tx_pos == 0) res.data = CH_SOH;
          else if (tx_pos == 1) res.data = pkt_no;
          else if (tx_pos == 2) res.data = ~pkt_no;
          else if (tx_pos < 3 + BLOCK_BYTES) res.data = block_buf[ADDR_W'(tx_pos - 8'd3)];
          else if (tx_pos == 3 + BLOCK_BYTES) res.data = crc_on ? check[15:8] : check[7:0];
          else res.data = check[7:0];
          if (res.eop) begin
            tx_pos = '0;
            ph = PH_WAIT_ACK;
          end else begin
            tx_pos = tx_pos + 8'd1;
          end
        end else if (ph == PH_EOT) begin
          res.kind = KIND_BYTE;
          res.data = CH_EOT;
          res.eop = 1'b1;
          emit = 1'b1;
          ph = PH_EOT_ACK;
        end
      end
      default: ;
    endcase
    if (emit) tx_due_q.push_back(res);
  endtask

  always @(posedge clk) begin
    sent_t want;
    if (rst) begin
      tx_due_q.delete();
      rearm_state();
      block_limit = BLOCK_COUNT_RST;
      mismatches = 0;
      results_checked = 0;
    end else begin
      if (cfg_wr_en) block_limit = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (tx_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d byte %02h eop %0b",
                     result_kind, tx_byte, end_of_packet);
        end else begin
          want = tx_due_q.pop_front();
          results_checked++;
          if (result_kind !== want.kind || tx_byte !== want.data ||
              end_of_packet !== want.eop) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result %0d: expected kind %0d byte %02h eop %0b,",
                        " got kind %0d byte %02h eop %0b"},
                       results_checked, want.kind, want.data, want.eop,
                       result_kind, tx_byte, end_of_packet);
          end
        end
      end
      if (in_valid && !in_stall) advance_sender(req_type, in_byte);
    end
    due_count = tx_due_q.size();
  end

endmodule

[tb/xmodem_packet_sender_tb.sv]
// Top of the XMODEM packet sender testbench: clock, reset, host and data stimulus,
// receiver stalls and the verdict. Depends on xps_pkg, the sender RTL and the checker.
`timescale 1ns / 1ps
module xmodem_packet_sender_tb;
  import xps_pkg::*;

  localparam logic [1:0] REQ_NONE        = 2'd3;
  localparam int         CYCLE_LIMIT     = 400_000;
  localparam int         ITEMS_PER_PHASE = 130;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type = '0;
  logic [7:0]  in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  tx_byte;
  logic        end_of_packet;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int send_idle_pct = 28;
  int stall_pct = 69;
  int items_sent = 0;
  int noise_items = 0;
  int sessions = 0;
  int transfers_done = 0;
  int cancels = 0;
  int resends = 0;
  int mismatches;
  int due_count;
  int results_checked;

  xmodem_packet_sender u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .in_byte       (in_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .tx_byte       (tx_byte),
    .end_of_packet (end_of_packet),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  xmodem_packet_sender_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_kind     (result_kind),
    .tx_byte         (tx_byte),
    .end_of_packet   (end_of_packet),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatches      (mismatches),
    .due_count       (due_count),
    .results_checked (results_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // hold valid high after a transfer; a drain, or an idle draw in the next call, lowers it
  task automatic put_item(input logic [1:0] req, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // drop in an item the sender ignores in its current phase
  task automatic noise(input int pct, input bit tx_ok, input bit data_ok,
                       input int t0, input int t1, input int t2);
    int         pick;
    logic [7:0] hb;
    if ($urandom_range(99) < pct) begin
      do pick = $urandom_range(3);
      while ((pick == 1 && !data_ok) || (pick == 2 && !tx_ok));
      noise_items++;
      case (pick)
        0: begin
          do hb = 8'($urandom_range(255));
          while (hb == t0 || hb == t1 || hb == t2);
          put_item(REQ_HOST, hb);
        end
        1: put_item(REQ_DATA, 8'($urandom_range(255)));
        2: put_item(REQ_TX, 8'($urandom_range(255)));
        default: put_item(REQ_NONE, 8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic drain_and_write(input logic [15:0] count);
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_session(input logic [15:0] count);
    logic use_crc;
    int   acked_pkts;
    bit   aborted;
    bit   settled;
    int   frame_len;
    int   r;
    drain_and_write(count);
    sessions++;
    noise(30, 1'b1, 1'b1, CH_ETX, CH_NAK, CH_C);
    if ($urandom_range(9) == 0) begin
      put_item(REQ_HOST, CH_ETX);
      cancels++;
    end
    use_crc = 1'($urandom_range(1));
    frame_len = BLOCK_BYTES + (use_crc ? 5 : 4);
    put_item(REQ_HOST, use_crc ? CH_C : CH_NAK);
    acked_pkts = 0;
    aborted = 1'b0;
    while (!aborted && acked_pkts < count) begin
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        noise(6, 1'b1, 1'b0, -1, -1, -1);
        r = $urandom_range(15);
        put_item(REQ_DATA, (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255)));
      end
      settled = 1'b0;
      while (!settled) begin
        for (int j = 0; j < frame_len; j++) begin
          noise(4, 1'b0, 1'b1, -1, -1, -1);
          put_item(REQ_TX, 8'($urandom_range(255)));
        end
        noise(30, 1'b1, 1'b1, CH_ACK, CH_NAK, CH_CAN);
        r = $urandom_range(99);
        // cut long transfers short after the second frame
        if (r < 8 || (count > 16'd8 && acked_pkts >= 1)) begin
          put_item(REQ_HOST, CH_CAN);
          cancels++;
          aborted = 1'b1;
          settled = 1'b1;
        end else if (r < 25) begin
          put_item(REQ_HOST, CH_NAK);
          resends++;
        end else begin
          put_item(REQ_HOST, CH_ACK);
          acked_pkts++;
          settled = 1'b1;
        end
      end
    end
    if (!aborted) begin
      noise(30, 1'b0, 1'b1, -1, -1, -1);
      put_item(REQ_TX, 8'($urandom_range(255)));
      noise(30, 1'b1, 1'b1, CH_ACK, -1, -1);
      put_item(REQ_HOST, CH_ACK);
      transfers_done++;
    end
  endtask

  initial begin
    int          base;
    int          r;
    logic [15:0] count;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    put_item(REQ_NONE, 8'hFF);
    put_item(REQ_DATA, 8'hAA);
    put_item(REQ_TX, 8'h00);
    put_item(REQ_HOST, CH_CAN);
    put_item(REQ_HOST, CH_ACK);
    put_item(REQ_HOST, CH_ETX);
    cancels++;
    drain_and_write(16'd0);
    put_item(REQ_HOST, CH_C);
    put_item(REQ_HOST, CH_ETX);
    put_item(REQ_DATA, 8'h55);
    put_item(REQ_HOST, CH_ACK);
    put_item(REQ_TX, 8'h00);
    put_item(REQ_TX, 8'hFF);
    put_item(REQ_HOST, CH_NAK);
    put_item(REQ_HOST, CH_CAN);
    put_item(REQ_DATA, 8'h00);
    put_item(REQ_HOST, CH_ACK);
    put_item(REQ_HOST, CH_NAK);
    put_item(REQ_TX, 8'h00);
    put_item(REQ_HOST, CH_ACK);
    transfers_done += 2;

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 28 : (p == 1) ? 69 : 0;
      stall_pct = (p == 0) ? 69 : (p == 1) ? 28 : 0;
      base = items_sent - noise_items;
      while (items_sent - noise_items - base < ITEMS_PER_PHASE) begin
        r = $urandom_range(9);
        if (sessions == 0) count = 16'hFFFF;
        else if (r == 0) count = 16'd0;
        else if (r <= 5) count = 16'd1;
        else if (r <= 7) count = 16'd2;
        else count = 16'($urandom_range(65535, 3));
        run_session(count);
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("run: %0d items driven (%0d ignored filler), %0d results checked",
             items_sent, noise_items, results_checked);
    $display("run: %0d sessions, %0d completed, %0d cancelled, %0d frames resent",
             sessions, transfers_done, cancels, resends);
    if (mismatches == 0 && due_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/xps_pkg.sv
rtl/xps_ram.sv
rtl/xps_ctrl.sv
rtl/xmodem_packet_sender.sv
tb/xmodem_packet_sender_checker.sv
tb/xmodem_packet_sender_tb.sv
